### rtl/b64enc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
package b64enc_pkg;

   localparam int CharWidth  = 7;
   localparam int ByteWidth  = 8;
   localparam int MaxChars   = 4;
   localparam int IdxWidth   = $clog2(MaxChars);
   localparam int QueueDepth = 2;
   localparam int QptrWidth  = $clog2(QueueDepth);
   localparam int QcntWidth  = $clog2(QueueDepth + 1);

   localparam logic [CharWidth-1:0] PAD_CHAR = 7'h3D;

   // Position inside the current three-byte group.
   typedef enum logic [2:0] {
      PH_0 = 3'b001,
      PH_1 = 3'b010,
      PH_2 = 3'b100
   } phase_type;

   // One classified byte: the characters it yields, the index of its last
   // character, and whether that last character ends the message.
   typedef struct packed {
      logic [MaxChars-1:0][CharWidth-1:0] chars;
      logic [IdxWidth-1:0]                last_idx;
      logic                               eom;
   } entry_type;

   function automatic logic [CharWidth-1:0] alphabet(input logic [5:0] v);
      logic [CharWidth-1:0] code;
      code = 7'h2F;
      if (v < 6'd26) begin
         code = 7'h41 + {1'b0, v};
      end else if (v < 6'd52) begin
         code = 7'h61 + {1'b0, v} - 7'd26;
      end else if (v < 6'd62) begin
         code = 7'h30 + {1'b0, v} - 7'd52;
      end else if (v == 6'd62) begin
         code = 7'h2B;
      end
      return code;
   endfunction

endpackage

### rtl/b64enc_front.sv
`timescale 1ns / 1ps
// Front end: takes one byte per transfer and turns it into the characters it completes.
module b64enc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [b64enc_pkg::ByteWidth-1:0] req_data_byte,
   input  logic                          req_end_of_message,
   input  logic                          queue_full,
   output logic                          push,
   output b64enc_pkg::entry_type         push_entry
);
   import b64enc_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [3:0] left_ff, left_in;
   logic [7:0] b;

   assign b    = req_data_byte;
   assign push = req_valid && !queue_full;

   always_comb begin
      phase_in   = phase_ff;
      left_in    = left_ff;
      push_entry = '0;
      push_entry.eom = req_end_of_message;
      unique case (phase_ff)
         PH_1: begin
            push_entry.chars[0] = alphabet({left_ff[1:0], b[7:4]});
            if (req_end_of_message) begin
               push_entry.chars[1] = alphabet({b[3:0], 2'b00});
               push_entry.chars[2] = PAD_CHAR;
               push_entry.last_idx = IdxWidth'(2);
               phase_in = PH_0;
               left_in  = '0;
            end else begin
               push_entry.last_idx = '0;
               phase_in = PH_2;
               left_in  = b[3:0];
            end
         end
         PH_2: begin
            push_entry.chars[0] = alphabet({left_ff, b[7:6]});
            push_entry.chars[1] = alphabet(b[5:0]);
            push_entry.last_idx = IdxWidth'(1);
            phase_in = PH_0;
            left_in  = '0;
         end
         default: begin
            push_entry.chars[0] = alphabet(b[7:2]);
            if (req_end_of_message) begin
               push_entry.chars[1] = alphabet({b[1:0], 4'b0000});
               push_entry.chars[2] = PAD_CHAR;
               push_entry.chars[3] = PAD_CHAR;
               push_entry.last_idx = IdxWidth'(3);
               phase_in = PH_0;
               left_in  = '0;
            end else begin
               push_entry.last_idx = '0;
               phase_in = PH_1;
               left_in  = {2'b00, b[1:0]};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_0;
         left_ff  <= '0;
      end else if (push) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

### rtl/b64enc_queue.sv
`timescale 1ns / 1ps
// Short queue of classified bytes between the front end and the character sequencer.
module b64enc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  b64enc_pkg::entry_type push_entry,
   input  logic                  pop,
   output b64enc_pkg::entry_type head_entry,
   output logic                  full,
   output logic                  empty
);
   import b64enc_pkg::*;

   entry_type              slots_ff [QueueDepth];
   logic [QptrWidth-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QcntWidth-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full       = (count_ff == QcntWidth'(QueueDepth));
   assign empty      = (count_ff == '0);
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;
   assign head_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QcntWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QcntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QptrWidth'(QueueDepth - 1)) ? '0
                                                                   : wr_ptr_ff + QptrWidth'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QptrWidth'(QueueDepth - 1)) ? '0
                                                                   : rd_ptr_ff + QptrWidth'(1);
         end
      end
   end

endmodule

### rtl/b64enc_back.sv
`timescale 1ns / 1ps
// Back end: sends the queued characters out one per transfer through an output register.
module b64enc_back (
   input  logic                              clock,
   input  logic                              reset,
   input  b64enc_pkg::entry_type             head_entry,
   input  logic                              empty,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [b64enc_pkg::CharWidth-1:0]  rsp_ascii_char,
   output logic                              rsp_final_char
);
   import b64enc_pkg::*;

   logic [IdxWidth-1:0]  idx_ff;
   logic                 valid_ff;
   logic [CharWidth-1:0] char_ff;
   logic                 final_ff;
   logic                 advance, load, at_last;

   assign advance = !valid_ff || !rsp_stall;
   assign load    = advance && !empty;
   assign at_last = (idx_ff == head_entry.last_idx);
   assign pop     = load && at_last;

   assign rsp_valid      = valid_ff;
   assign rsp_ascii_char = char_ff;
   assign rsp_final_char = final_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff  <= head_entry.chars[idx_ff];
         final_ff <= head_entry.eom && at_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (advance) begin
            valid_ff <= load;
         end
         if (load) begin
            idx_ff <= at_last ? '0 : idx_ff + IdxWidth'(1);
         end
      end
   end

endmodule

### rtl/base64_stream_encoder_core.sv
`timescale 1ns / 1ps
// Top level of the base64 stream encoder: front end, queue and character sequencer.
//
//   channel | direction | ports
//   --------+-----------+----------------------------------------------------
//   req     | in        | req_valid, req_stall, req_data_byte, req_end_of_message
//   rsp     | out       | rsp_valid, rsp_stall, rsp_ascii_char, rsp_final_char
//
// A byte is classified in the cycle of its transfer and queued; the sequencer sends one
// character per cycle while rsp_stall is low, and a byte yields one or two characters in a
// group, up to four on the last byte. The single output port limits the byte rate.
// Reset clears the group position, the queue and the output valid flag.
// A stalled output only backs up the two-entry queue; req_stall rises once it is full.
module base64_stream_encoder_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [b64enc_pkg::ByteWidth-1:0]  req_data_byte,
   input  logic                              req_end_of_message,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [b64enc_pkg::CharWidth-1:0]  rsp_ascii_char,
   output logic                              rsp_final_char
);
   import b64enc_pkg::*;

   entry_type push_entry, head_entry;
   logic      push, pop, full, empty;

   assign req_stall = full;

   b64enc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .queue_full         (full),
      .push               (push),
      .push_entry         (push_entry)
   );

   b64enc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .full       (full),
      .empty      (empty)
   );

   b64enc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_entry     (head_entry),
      .empty          (empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_final_char (rsp_final_char)
   );

endmodule
